/* sv/ssr_pkg.sv */
// Shared definitions for the shift-subtract remainder block.
// Holds the port data width, the default operand width and the command bundle
// that runs from the controller to the datapath. Depends on nothing.
`default_nettype none

package ssr_pkg;

  // Width of the dividend, divisor and remainder fields on the channels.
  localparam int unsigned DATA_W = 64;

  // Default number of operand bits that take part in the division.
  localparam int unsigned WIDTH_DEF = 64;

  typedef struct packed {
    logic load;     // capture the operands and clear the partial remainder
    logic step;     // one restoring compare-and-subtract step
    logic publish;  // copy the finished remainder into the output register
  } ssr_cmd_t;

endpackage : ssr_pkg

`default_nettype wire

/* sv/ssr_in_if.sv */
// Operand channel: valid/ready handshake carrying the dividend and the divisor.
// Depends on ssr_pkg for the field width.
`default_nettype none

interface ssr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssr_pkg::DATA_W-1:0]  dividend;
  logic [ssr_pkg::DATA_W-1:0]  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface : ssr_in_if

`default_nettype wire

/* sv/ssr_out_if.sv */
// Result channel: valid/ready handshake carrying the remainder.
// Depends on ssr_pkg for the field width.
`default_nettype none

interface ssr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssr_pkg::DATA_W-1:0]  remainder;

  modport source (output valid, output remainder, input ready);
  modport sink   (input valid, input remainder, output ready);
endinterface : ssr_out_if

`default_nettype wire

/* sv/shift_subtract_remainder.sv */
// Top level of the shift-subtract remainder block: joins controller and datapath.
// Depends on ssr_pkg, ssr_in_if, ssr_out_if, ssr_ctrl and ssr_datapath.
//
// Returns the remainder of an unsigned dividend divided by an unsigned divisor,
// using the low WIDTH bits of each; a zero divisor returns the dividend, and
// result bits at WIDTH and above are zero. An operand transfer is taken only
// while the block is idle. The remainder is formed by a restoring division
// with one compare-and-subtract step per clock, one step per operand bit, on
// a single shared subtractor. After the last step the partial remainder is
// copied into the output register once that register is free, and the block
// then returns to idle and can take the next operands.
// The output register is followed by the next item's load, so a waiting result
// does not hold up the following operands beyond the item in flight.
`default_nettype none

module shift_subtract_remainder #(
  parameter int unsigned WIDTH = ssr_pkg::WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssr_in_if.sink     in_i,
  ssr_out_if.source  out_o
);

  ssr_pkg::ssr_cmd_t cmd;

  ssr_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  ssr_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .dividend_i  (in_i.dividend),
    .divisor_i   (in_i.divisor),
    .remainder_o (out_o.remainder)
  );

endmodule : shift_subtract_remainder

`default_nettype wire

/* sv/ssr_datapath.sv */
// Datapath of the shift-subtract remainder block: operand registers, partial
// remainder with its compare-and-subtract step, and the output register.
// Depends on ssr_pkg for the command bundle and the field width.
`default_nettype none

module ssr_datapath #(
  parameter int unsigned WIDTH = ssr_pkg::WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire ssr_pkg::ssr_cmd_t          cmd_i,
  input  wire logic [ssr_pkg::DATA_W-1:0] dividend_i,
  input  wire logic [ssr_pkg::DATA_W-1:0] divisor_i,
  output logic      [ssr_pkg::DATA_W-1:0] remainder_o
);

  logic [WIDTH-1:0] num_q, num_d;   // dividend bits still to be brought down
  logic [WIDTH-1:0] den_q, den_d;
  logic [WIDTH-1:0] rem_q, rem_d;   // partial remainder, below the divisor when that is nonzero
  logic [WIDTH-1:0] res_q, res_d;   // output register

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // Bring down the next dividend bit and try to take the divisor off. With a
  // zero divisor nothing is taken off, so the dividend passes through.
  assign trial = {rem_q, num_q[WIDTH-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    res_d = res_q;
    if (cmd_i.load) begin
      num_d = dividend_i[WIDTH-1:0];
      den_d = divisor_i[WIDTH-1:0];
      rem_d = '0;
    end else if (cmd_i.step) begin
      num_d = {num_q[WIDTH-2:0], 1'b0};
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
      end else begin
        rem_d = trial[WIDTH-1:0];
      end
    end
    if (cmd_i.publish) begin
      res_d = rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign remainder_o = ssr_pkg::DATA_W'(res_q);

endmodule : ssr_datapath

`default_nettype wire

/* sv/ssr_ctrl.sv */
// Controller of the shift-subtract remainder block: sequences the load, the
// bit steps and the hand-over to the output register, and owns both handshakes.
// Depends on ssr_pkg for the command bundle.
`default_nettype none

module ssr_ctrl #(
  parameter int unsigned WIDTH = ssr_pkg::WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ssr_pkg::ssr_cmd_t      cmd_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;

  logic in_xfer;
  logic out_xfer;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  // The output register can take a new result when it is empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = in_xfer;
    cmd_o.step    = (state_q == ST_RUN);
    cmd_o.publish = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt_q   <= CntW'(WIDTH - 1);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule : ssr_ctrl

`default_nettype wire
